FILE: hw/rtl/waypoint_heading_guidance_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the waypoint heading guidance block
// Clocked on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_HEADING_GUIDANCE_TOP_ASSERT_SVH
`define WAYPOINT_HEADING_GUIDANCE_TOP_ASSERT_SVH

// Same-cycle implication
`define WHG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define WHG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/whg_pkg.sv
// ----------------------------------------------------------------------------
// whg_pkg
// Constants shared by the waypoint heading guidance block and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package whg_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 24;

  // angles in 1/128 degree
  localparam int HALF_TURN   = 23040;
  localparam int FULL_TURN   = 46080;
  localparam int SMALL_ERR   = 3840;
  localparam int FULL_RUDDER = 16384;
  localparam int RANGE_MAX   = 67108863;

  // CORDIC angle in 1/32768 degree
  localparam int QUARTER_Z     = 2949120;
  localparam int BEARING_ROUND = 128;

  // proportional rudder: (gain * |e| * 16 + 62) / 125, saturated at full rudder
  localparam int RUD_BIAS    = 62;
  localparam int RUD_NUM_MAX = 2048125;  // 16385 * 125
  localparam int RUD_RECIP   = 2147484;  // ceil(2^28 / 125)
  localparam int RUD_SHIFT   = 28;

  localparam int ATAN_TAB [24] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0
  };

  // register indexes
  localparam logic [2:0] REG_RADIUS  = 3'd0;
  localparam logic [2:0] REG_SLOWING = 3'd1;
  localparam logic [2:0] REG_GAIN    = 3'd2;
  localparam logic [2:0] REG_CRUISE  = 3'd3;
  localparam logic [2:0] REG_TURN    = 3'd4;

  localparam logic [23:0] RADIUS_RST  = 24'd1280;
  localparam logic [7:0]  SLOWING_RST = 8'd3;
  localparam logic [15:0] GAIN_RST    = 16'd1000;
  localparam logic [15:0] CRUISE_RST  = 16'd65535;
  localparam logic [15:0] TURN_RST    = 16'd32768;

endpackage

FILE: hw/rtl/waypoint_heading_guidance_top.sv
// ----------------------------------------------------------------------------
// waypoint_heading_guidance_top
// Proportional heading guidance towards a waypoint, one word in, one word out.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one word per clock, in order, unless the
// output stalls. R = min(COORD_WIDTH + 1, 32) is the root width. The pipeline
// depth is set by the one-bit-per-stage square root, then a 16-stage restoring
// divider for the slowing throttle. The CORDIC bearing runs alongside the root.
// When a result waits at the output and out_tready is low, the whole pipeline
// holds and in_tready drops with it.
`timescale 1ns / 1ps

module waypoint_heading_guidance_top #(
  parameter int CORDIC_STEPS = whg_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_WIDTH  = whg_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: own_x, own_y, heading[17], goal_x, goal_y, zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [((4*COORD_WIDTH+17+7)/8)*8-1:0] in_tdata,
  // out_tdata: throttle_cmd[16], rudder_cmd[16], range_to_goal[26],
  //            heading_error[16], reached[1], zero pad[5]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int XW    = CW + 11;
  localparam int ZW    = 25;
  localparam int SQW   = 2*CW + 1;
  localparam int SX_W  = 2*CW + 3;
  localparam int RW    = (CW + 1 > 32) ? 32 : CW + 1;
  localparam int S_W   = 2*RW;
  localparam int RMW   = RW + 2;
  localparam int EW    = 18;
  localparam int LIM_W = 32;
  localparam int NUM_W = 16 + RW;
  localparam int NG    = 6;
  localparam int CS    = CORDIC_STEPS;
  localparam int D0    = (3 + RW > 2 + CS + NG) ? 3 + RW : 2 + CS + NG;
  localparam int FS    = D0 + 17;
  localparam int NST   = FS + 1;

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [16:0]   hd;
    logic [SQW-1:0]       sqx;
    logic [SQW-1:0]       sqy;
    logic [S_W-1:0]       s;
    logic                 carry;
    logic                 reached;
    logic                 slow;
    logic [RMW-1:0]       rem;
    logic [RW-1:0]        root;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zb;
    logic signed [16:0]   brg;
    logic signed [15:0]   e;
    logic                 sm;
    logic [30:0]          p;
    logic [20:0]          nc;
    logic [42:0]          prod;
    logic signed [15:0]   rud;
    logic [15:0]          maxthr;
    logic [NUM_W-1:0]     num;
    logic [LIM_W-1:0]     drem;
    logic [15:0]          quo;
    logic [15:0]          thr;
    logic [25:0]          rng;
  } stage_t;

  // ---------------- configuration registers ----------------
  logic [23:0] radius_r;
  logic [7:0]  slow_factor_r;
  logic [15:0] gain_r, cruise_r, turn_r;
  logic [47:0] rsq_r;
  logic [LIM_W-1:0] lim_r;
  logic [63:0] limsq_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= whg_pkg::RADIUS_RST;
      slow_factor_r <= whg_pkg::SLOWING_RST;
      gain_r        <= whg_pkg::GAIN_RST;
      cruise_r      <= whg_pkg::CRUISE_RST;
      turn_r        <= whg_pkg::TURN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        whg_pkg::REG_RADIUS:  radius_r      <= cfg_pwdata[23:0];
        whg_pkg::REG_SLOWING: slow_factor_r <= cfg_pwdata[7:0];
        whg_pkg::REG_GAIN:    gain_r        <= cfg_pwdata[15:0];
        whg_pkg::REG_CRUISE:  cruise_r      <= cfg_pwdata[15:0];
        whg_pkg::REG_TURN:    turn_r        <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // derived limits, registered; the squared slowing limit is registered from lim_r
  always_ff @(posedge clk) begin
    rsq_r   <= 48'(radius_r) * 48'(radius_r);
    lim_r   <= LIM_W'(slow_factor_r) * LIM_W'(radius_r);
    limsq_r <= 64'(lim_r) * 64'(lim_r);
  end

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      whg_pkg::REG_RADIUS:  cfg_prdata = 32'(radius_r);
      whg_pkg::REG_SLOWING: cfg_prdata = 32'(slow_factor_r);
      whg_pkg::REG_GAIN:    cfg_prdata = 32'(gain_r);
      whg_pkg::REG_CRUISE:  cfg_prdata = 32'(cruise_r);
      whg_pkg::REG_TURN:    cfg_prdata = 32'(turn_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // ---------------- input fields ----------------
  logic signed [CW-1:0] own_x, own_y, goal_x, goal_y;
  logic signed [16:0]   heading;

  assign own_x   = in_tdata[CW-1:0];
  assign own_y   = in_tdata[2*CW-1:CW];
  assign heading = in_tdata[2*CW+16:2*CW];
  assign goal_x  = in_tdata[3*CW+16:2*CW+17];
  assign goal_y  = in_tdata[4*CW+16:3*CW+17];

  // ---------------- pipeline control ----------------
  stage_t         pipe_r   [NST];
  stage_t         pipe_nxt [NST];
  logic [NST-1:0] vld_r;
  logic           en;

  assign en        = ~vld_r[NST-1] | out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) pipe_r[i] <= pipe_nxt[i];
    end
  end

  // ---------------- stage logic ----------------
  for (genvar k = 0; k < NST; k++) begin : g_st
    localparam int CI = (k >= 2 && k < 2 + CS) ? k - 2 : 0;
    localparam int SJ = (k >= 3 && k < 3 + RW) ? k - 3 : 0;
    localparam int PI = RW - 1 - SJ;
    localparam int DK = (k > D0 && k <= D0 + 16) ? k - D0 - 1 : 0;
    localparam int GB = 2 + CS;

    stage_t prv, nxt;

    if (k == 0) begin : g_first
      assign prv = '0;
    end else begin : g_rest
      assign prv = pipe_r[k-1];
    end

    always_comb begin
      logic [DW-1:0]        ax, ay;
      logic signed [XW-1:0] x0, y0, xsh, ysh;
      logic [SX_W-1:0]      ssum;
      logic [RMW+1:0]       rem2, trial;
      logic signed [ZW-1:0] zr;
      logic signed [EW-1:0] e0, e1;
      logic [14:0]          mag, q;
      logic [34:0]          n;
      logic [LIM_W-1:0]     rin;
      logic [LIM_W:0]       r2;
      ax = '0; ay = '0; x0 = '0; y0 = '0; xsh = '0; ysh = '0; ssum = '0;
      rem2 = '0; trial = '0; zr = '0; e0 = '0; e1 = '0; mag = '0; q = '0;
      n = '0; rin = '0; r2 = '0;
      nxt = prv;

      // offsets to the goal
      if (k == 0) begin
        nxt.dx = DW'(goal_x) - DW'(own_x);
        nxt.dy = DW'(goal_y) - DW'(own_y);
        nxt.hd = heading;
      end

      // squares, CORDIC pre-rotation into the right half plane
      if (k == 1) begin
        ax = prv.dx[DW-1] ? DW'(-prv.dx) : DW'(prv.dx);
        ay = prv.dy[DW-1] ? DW'(-prv.dy) : DW'(prv.dy);
        nxt.sqx = SQW'(ax) * SQW'(ax);
        nxt.sqy = SQW'(ay) * SQW'(ay);
        x0 = XW'(prv.dx) <<< 8;
        y0 = XW'(prv.dy) <<< 8;
        nxt.zb = (prv.dx == '0) && (prv.dy == '0);
        if (prv.dx[DW-1]) begin
          if (!prv.dy[DW-1]) begin
            nxt.x = y0;
            nxt.y = -x0;
            nxt.z = ZW'(whg_pkg::QUARTER_Z);
          end else begin
            nxt.x = -y0;
            nxt.y = x0;
            nxt.z = -ZW'(whg_pkg::QUARTER_Z);
          end
        end else begin
          nxt.x = x0;
          nxt.y = y0;
          nxt.z = '0;
        end
      end

      // squared distance; beyond 2*R bits counts as a carry
      if (k == 2) begin
        ssum      = SX_W'(prv.sqx) + SX_W'(prv.sqy);
        nxt.s     = ssum[S_W-1:0];
        nxt.carry = |ssum[SX_W-1:S_W];
      end

      // CORDIC vectoring step
      if (k >= 2 && k < 2 + CS) begin
        xsh = prv.x >>> CI;
        ysh = prv.y >>> CI;
        if (!prv.y[XW-1] && (prv.y != '0)) begin
          nxt.x = prv.x + ysh;
          nxt.y = prv.y - xsh;
          nxt.z = prv.z + ZW'(whg_pkg::ATAN_TAB[CI]);
        end else begin
          nxt.x = prv.x - ysh;
          nxt.y = prv.y + xsh;
          nxt.z = prv.z - ZW'(whg_pkg::ATAN_TAB[CI]);
        end
      end

      // arrival and slowing zone tests
      if (k == 3) begin
        nxt.reached = !prv.carry && (64'(prv.s) < 64'(rsq_r));
        nxt.slow    = !prv.carry && (64'(prv.s) < limsq_r);
      end

      // square root, one result bit a stage
      if (k >= 3 && k < 3 + RW) begin
        rem2  = {prv.rem, prv.s[2*PI+1 -: 2]};
        trial = (RMW+2)'({prv.root, 2'b01});
        if (rem2 >= trial) begin
          nxt.rem  = RMW'(rem2 - trial);
          nxt.root = {prv.root[RW-2:0], 1'b1};
        end else begin
          nxt.rem  = rem2[RMW-1:0];
          nxt.root = {prv.root[RW-2:0], 1'b0};
        end
      end

      // bearing: round to 1/128 degree and clamp
      if (k == GB) begin
        zr = (prv.z + ZW'(whg_pkg::BEARING_ROUND)) >>> 8;
        if (prv.zb) begin
          nxt.brg = '0;
        end else if (zr > ZW'(whg_pkg::HALF_TURN)) begin
          nxt.brg = 17'(whg_pkg::HALF_TURN);
        end else if (zr < -ZW'(whg_pkg::HALF_TURN)) begin
          nxt.brg = -17'(whg_pkg::HALF_TURN);
        end else begin
          nxt.brg = 17'(zr);
        end
      end

      // heading error, wrapped into half a turn
      if (k == GB + 1) begin
        e0 = EW'(prv.brg) - EW'(prv.hd);
        if (e0 >= EW'(whg_pkg::HALF_TURN) || e0 <= -EW'(whg_pkg::HALF_TURN)) begin
          e0 = (!e0[EW-1]) ? e0 - EW'(whg_pkg::FULL_TURN) : e0 + EW'(whg_pkg::FULL_TURN);
        end
        if (e0 > EW'(whg_pkg::HALF_TURN)) begin
          e1 = e0 - EW'(whg_pkg::FULL_TURN);
        end else if (e0 < -EW'(whg_pkg::HALF_TURN)) begin
          e1 = e0 + EW'(whg_pkg::FULL_TURN);
        end else begin
          e1 = e0;
        end
        nxt.e = 16'(e1);
      end

      // gain product and mode select
      if (k == GB + 2) begin
        mag = prv.e[15] ? 15'(-prv.e) : 15'(prv.e);
        nxt.sm     = mag < 15'(whg_pkg::SMALL_ERR);
        nxt.p      = 31'(gain_r) * 31'(mag);
        nxt.maxthr = (mag < 15'(whg_pkg::SMALL_ERR)) ? cruise_r : turn_r;
      end

      // scale by 16, add rounding bias, clip ahead of the divide by 125
      if (k == GB + 3) begin
        n = (35'(prv.p) << 4) + 35'(whg_pkg::RUD_BIAS);
        nxt.nc = (n > 35'(whg_pkg::RUD_NUM_MAX)) ? 21'(whg_pkg::RUD_NUM_MAX) : 21'(n);
      end

      // divide by 125 through the reciprocal
      if (k == GB + 4) begin
        nxt.prod = 43'(prv.nc) * 43'(whg_pkg::RUD_RECIP);
      end

      // rudder command
      if (k == GB + 5) begin
        q = prv.prod[whg_pkg::RUD_SHIFT +: 15];
        if (q > 15'(whg_pkg::FULL_RUDDER)) q = 15'(whg_pkg::FULL_RUDDER);
        if (prv.sm) begin
          nxt.rud = prv.e[15] ? -16'(q) : 16'(q);
        end else if (!prv.e[15] && (prv.e != '0)) begin
          nxt.rud = 16'(whg_pkg::FULL_RUDDER);
        end else begin
          nxt.rud = -16'(whg_pkg::FULL_RUDDER);
        end
      end

      // slowing numerator
      if (k == D0) begin
        nxt.num = NUM_W'(prv.maxthr) * NUM_W'(prv.root);
      end

      // restoring divide by the slowing limit
      if (k > D0 && k <= D0 + 16) begin
        if (DK == 0) begin
          rin = LIM_W'(prv.num[NUM_W-1:16]);
        end else begin
          rin = prv.drem;
        end
        r2 = {rin, prv.num[15-DK]};
        if (r2 >= {1'b0, lim_r}) begin
          nxt.drem = LIM_W'(r2 - {1'b0, lim_r});
          nxt.quo  = {prv.quo[14:0], 1'b1};
        end else begin
          nxt.drem = r2[LIM_W-1:0];
          nxt.quo  = {prv.quo[14:0], 1'b0};
        end
      end

      // output word
      if (k == FS) begin
        if (prv.carry || (33'(prv.root) > 33'(whg_pkg::RANGE_MAX))) begin
          nxt.rng = 26'(whg_pkg::RANGE_MAX);
        end else begin
          nxt.rng = 26'(prv.root);
        end
        if (prv.reached) begin
          nxt.thr = '0;
          nxt.rud = '0;
          nxt.e   = '0;
        end else begin
          nxt.thr = prv.slow ? prv.quo : prv.maxthr;
        end
      end
    end

    assign pipe_nxt[k] = nxt;
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {5'b0, pipe_r[NST-1].reached, pipe_r[NST-1].e,
                       pipe_r[NST-1].rng, pipe_r[NST-1].rud, pipe_r[NST-1].thr};

endmodule

FILE: hw/rtl/whg_checker.sv
// ----------------------------------------------------------------------------
// whg_checker
// Port-level checks on the guidance result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "waypoint_heading_guidance_top_assert.svh"

module whg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // a stalled word holds
  `WHG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output word changed while stalled")

  // on arrival nothing is commanded
  `WHG_ASSERT_NOW(a_reached_idle, out_tvalid && out_tdata[74], (out_tdata[15:0] == 16'd0) && (out_tdata[31:16] == 16'd0) && (out_tdata[73:58] == 16'd0), "reached word commands motion")

  // rudder stays within full deflection
  `WHG_ASSERT_NOW(a_rudder_range, out_tvalid, ($signed(out_tdata[31:16]) <= whg_pkg::FULL_RUDDER) && ($signed(out_tdata[31:16]) >= -whg_pkg::FULL_RUDDER), "rudder beyond full deflection")

  // heading error is wrapped
  `WHG_ASSERT_NOW(a_err_wrapped, out_tvalid, ($signed(out_tdata[73:58]) <= whg_pkg::HALF_TURN) && ($signed(out_tdata[73:58]) >= -whg_pkg::HALF_TURN), "heading error not wrapped")

endmodule

bind waypoint_heading_guidance_top whg_checker u_whg_checker (.*);
